@@ design/pnc_pkg.sv @@
// Shared constants for the perfect-number checker.
// No dependencies; imported by pnc_div and perfect_number_check.
package pnc_pkg;

    localparam int NUM_WIDTH_DEF = 31;
    localparam int SUM_W         = 34;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

@@ design/pnc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pnc_pkg for the default operand width.
module pnc_div
    import pnc_pkg::*;
#(
    parameter int W = NUM_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dsr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W:0] shifted;
    logic [W:0] diff;

    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        diff    = shifted - {1'b0, r_dsr};
    end

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            // borrow out of the top bit means the trial subtract failed
            if (!diff[W]) begin
                n_rem = diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = shifted[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

@@ design/perfect_number_check.sv @@
// Perfect-number test by trial division, one shared divider and one add/sub unit.
// Per item: trial divisors run from 1 up to floor(sqrt(n)); each one starts pnc_div
// and waits for its done. A divisor that divides evenly is added to the sum, and so
// is its quotient when that differs; at the end n itself is subtracted.
// One item at a time: s_axis_tready is high only while idle. The result waits in
// an output register, so the next beat may be taken before it is read.
// Synchronous active-low reset clears the sequencer and the output valid.
module perfect_number_check
    import pnc_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [NUM_WIDTH-1:0] number, zero padding above
    input  logic [((NUM_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [0] is_perfect, [34:1] aliquot_sum, zero padding above
    output logic [((SUM_W + 8) / 8) * 8 - 1:0]     m_axis_tdata
);

    localparam int W      = NUM_WIDTH;
    localparam int AW     = NUM_WIDTH + 4;          // divisor sum stays below 8n
    localparam int EW     = (AW > SUM_W) ? AW : SUM_W;
    localparam int OUT_TW = ((SUM_W + 8) / 8) * 8;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_ADD_D = 3'd3;
    localparam logic [2:0] S_ADD_Q = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [W-1:0]  r_num;
    logic [W-1:0]  r_div, n_div;
    logic [W-1:0]  r_quo;
    logic [AW-1:0] r_acc, n_acc;
    logic [AW-1:0] r_ali;
    logic          r_ovalid, n_ovalid;
    logic          r_operf;
    logic [SUM_W-1:0] r_osum;

    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;

    // shared add/sub unit
    logic [AW-1:0] au_b;
    logic          au_sub;
    logic [AW-1:0] au_res;

    logic [EW-1:0] ali_ext;
    logic          ali_sat;
    logic          perfect;
    logic          out_free;

    pnc_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (r_div),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_comb begin
        au_sub = 1'b0;
        au_b   = AW'(r_div);
        case (r_state)
            S_ADD_Q: au_b = AW'(r_quo);
            S_FIN: begin
                au_b   = AW'(r_num);
                au_sub = 1'b1;
            end
            default: au_b = AW'(r_div);
        endcase
        au_res = r_acc + (au_sub ? ~au_b : au_b) + AW'(au_sub);
    end

    assign out_free  = !r_ovalid || m_axis_tready;
    assign div_start = (r_state == S_START);

    always_comb begin
        n_state  = r_state;
        n_div    = r_div;
        n_acc    = r_acc;
        n_ovalid = r_ovalid;
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_div   = W'(1);
                    n_acc   = '0;
                    // zero skips the divisor loop and leaves a zero sum
                    n_state = (s_axis_tdata[W-1:0] == '0) ? S_FIN : S_START;
                end
            end
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_done) begin
                    if (r_div > div_quo) begin
                        n_state = S_FIN;
                    end else if (div_rem == '0) begin
                        n_state = S_ADD_D;
                    end else begin
                        n_div   = r_div + 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_ADD_D: begin
                n_acc = au_res;
                if (r_quo != r_div) begin
                    n_state = S_ADD_Q;
                end else begin
                    n_div   = r_div + 1'b1;
                    n_state = S_START;
                end
            end
            S_ADD_Q: begin
                n_acc   = au_res;
                n_div   = r_div + 1'b1;
                n_state = S_START;
            end
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ali_ext = EW'(r_ali);
        ali_sat = ali_ext > EW'(SUM_MAX);
        perfect = (r_ali == AW'(r_num)) && (r_num != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_div <= n_div;
        r_acc <= n_acc;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_num <= s_axis_tdata[W-1:0];
        end
        if (r_state == S_WAIT && div_done) begin
            r_quo <= div_quo;
        end
        if (r_state == S_FIN) begin
            r_ali <= au_res;
        end
        if (r_state == S_OUT && out_free) begin
            r_operf <= perfect;
            r_osum  <= ali_sat ? SUM_MAX : ali_ext[SUM_W-1:0];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TW'({r_osum, r_operf});

endmodule
